### src/nsq_pkg.sv
// Shared types, constants and helpers for the neighbor-state Q-learning block.
`timescale 1ns / 1ps
`default_nettype none
package nsq_pkg;

  localparam int NUM_CORES = 400;
  localparam int CORE_AW   = $clog2(NUM_CORES);
  localparam int Q_STATES  = 35;
  localparam int Q_ROWS    = 3;
  localparam int TBL_DEPTH = Q_STATES * Q_ROWS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CLR_N     = (NUM_CORES > TBL_DEPTH) ? NUM_CORES : TBL_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N);

  localparam logic [5:0]  NO_STATE    = 6'd63;
  // ceil(2^31 / 100), exact floor(n/100) for 24-bit n
  localparam logic [24:0] DIV100_M    = 25'd21474837;
  localparam logic signed [26:0] REWARD_BASE = 27'sd6553600;

  localparam logic [1:0] KIND_OBS = 2'd0;
  localparam logic [1:0] KIND_WR  = 2'd1;
  localparam logic [1:0] KIND_RD  = 2'd2;

  localparam logic [1:0] REG_LEARN  = 2'd0;
  localparam logic [1:0] REG_DISC   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  typedef struct packed {
    logic [5:0]  last;
    logic [23:0] start;
    logic [7:0]  cnt;
  } core_ent_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] mag;
  } rw_req_t;

  typedef struct packed {
    logic               done;
    logic signed [26:0] reward;
  } rw_rsp_t;

  function automatic logic [5:0] nbr_state(input logic [2:0] x, input logic [2:0] y,
                                           input logic [2:0] z);
    logic [5:0] sx;
    logic [4:0] k;
    logic [7:0] p;
    case (x)
      3'd0:    sx = 6'd0;
      3'd1:    sx = 6'd15;
      3'd2:    sx = 6'd25;
      3'd3:    sx = 6'd31;
      default: sx = 6'd34;
    endcase
    k = 5'd11 - {2'b0, y} - {1'b0, x, 1'b0};
    p = {5'b0, y} * {3'b0, k};
    return sx + p[6:1] + {3'b0, z};
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [1:0] row, input logic [5:0] col);
    logic [7:0] a;
    a = {6'b0, row} * 8'd35 + {2'b0, col};
    return TBL_AW'(a);
  endfunction

endpackage
`default_nettype wire

### src/nsq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nsq_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/nsq_reward.sv
// Iterative reward unit: square, bitwise integer sqrt, restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module nsq_reward import nsq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire rw_req_t req,
  output rw_rsp_t      rsp
);

  typedef enum logic [2:0] {R_IDLE, R_SQ, R_SQRT, R_DINIT, R_DIV, R_FIN} rst_t;

  rst_t               state_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [63:0]        n_r;
  logic [63:0]        root_r;
  logic [63:0]        bit_r;
  logic [55:0]        rem_r;
  logic [55:0]        dvs_r;
  logic [23:0]        quo_r;
  logic [4:0]         qc_r;
  logic               done_r;
  logic signed [26:0] rwd_r;
  logic [63:0]        trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        R_IDLE: begin
          if (req.start) begin
            mag_r   <= req.mag;
            neg_r   <= req.neg;
            done_r  <= 1'b0;
            state_r <= R_SQ;
          end
        end
        R_SQ: begin
          n_r     <= (64'd10 << 32) + {32'b0, mag_r} * {32'b0, mag_r};
          root_r  <= 64'd0;
          bit_r   <= 64'h4000_0000_0000_0000;
          state_r <= R_SQRT;
        end
        R_SQRT: begin
          if (n_r >= trial) begin
            n_r    <= n_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= R_DINIT;
          end
        end
        R_DINIT: begin
          rem_r   <= {8'b0, mag_r, 16'b0} * 56'd200 + {25'b0, root_r[31:1]};
          dvs_r   <= {1'b0, root_r[31:0], 23'b0};
          quo_r   <= 24'd0;
          qc_r    <= 5'd23;
          state_r <= R_DIV;
        end
        R_DIV: begin
          if (rem_r >= dvs_r) begin
            rem_r <= rem_r - dvs_r;
            quo_r <= {quo_r[22:0], 1'b1};
          end else begin
            quo_r <= {quo_r[22:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
          qc_r  <= qc_r - 5'd1;
          if (qc_r == 5'd0) begin
            state_r <= R_FIN;
          end
        end
        R_FIN: begin
          rwd_r   <= neg_r ? REWARD_BASE + $signed({3'b0, quo_r})
                           : REWARD_BASE - $signed({3'b0, quo_r});
          done_r  <= 1'b1;
          state_r <= R_IDLE;
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.reward = rwd_r;

endmodule
`default_nettype wire

### src/neighbor_state_q_learning_update.sv
// Top level: config registers, sequencer, per-core and score memories.
// Path: a table write or rejected word goes from idle to the output state; a read or
// non-updating observation passes the memory read state; a learning update waits on the
// reward unit, whose 32-step sqrt and 24-step divide dominate. One word in flight, and
// the next word is taken while the result waits.
// Reset: synchronous active-low; then a clear of both memories.
`timescale 1ns / 1ps
`default_nettype none
module neighbor_state_q_learning_update import nsq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // core_index, occupied, task_class, near_count_a, near_count_b, near_count_c,
  // fit_now, entry_index, entry_value, zero pad
  input  wire logic [87:0] in_tdata,
  // kind
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // core_state, state_moved, table_written, score_out, reward_out, zero pad
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_QA, S_QB, S_DQ, S_SQ, S_RWAIT,
    S_DISC, S_T, S_MA, S_MB, S_WR, S_OUT
  } st_t;

  // config
  logic [15:0] learn_rate_r, discount_r, delta_scale_r;
  logic [7:0]  stable_limit_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= 16'd655;
      discount_r     <= 16'd39322;
      stable_limit_r <= 8'd200;
      delta_scale_r  <= 16'd197;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_LEARN: learn_rate_r   <= cfg_pwdata[15:0];
        REG_DISC:  discount_r     <= cfg_pwdata[15:0];
        REG_LIMIT: stable_limit_r <= cfg_pwdata[7:0];
        REG_SCALE: delta_scale_r  <= cfg_pwdata[15:0];
        default:   learn_rate_r   <= learn_rate_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LEARN: cfg_prdata = {16'b0, learn_rate_r};
      REG_DISC:  cfg_prdata = {16'b0, discount_r};
      REG_LIMIT: cfg_prdata = {24'b0, stable_limit_r};
      REG_SCALE: cfg_prdata = {16'b0, delta_scale_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // input word fields
  logic [8:0]  in_core;
  logic        in_occ;
  logic [1:0]  in_row;
  logic [2:0]  in_a, in_b, in_c;
  logic [23:0] in_fit;
  logic [5:0]  in_col;
  logic [31:0] in_ev;
  logic [4:0]  nsum;
  logic        ok_tbl, ok_obs, in_fire;

  assign in_core = in_tdata[8:0];
  assign in_occ  = in_tdata[9];
  assign in_row  = in_tdata[11:10];
  assign in_a    = in_tdata[14:12];
  assign in_b    = in_tdata[17:15];
  assign in_c    = in_tdata[20:18];
  assign in_fit  = in_tdata[44:21];
  assign in_col  = in_tdata[50:45];
  assign in_ev   = in_tdata[82:51];
  assign nsum    = {2'b0, in_a} + {2'b0, in_b} + {2'b0, in_c};
  assign ok_tbl  = (in_row < 2'd3) && (in_col < 6'd35);
  assign ok_obs  = in_occ && ({4'b0, in_core} < 13'(NUM_CORES)) && (in_row < 2'd3) &&
                   (nsum <= 5'd4);

  st_t                state_r;
  logic [CLR_W-1:0]   clr_idx_r;
  logic [1:0]         kind_r;
  logic [CORE_AW-1:0] core_r;
  logic [1:0]         row_r;
  logic [5:0]         s_r;
  logic [23:0]        fit_r;
  logic [23:0]        sf_r;
  logic [17:0]        qa_r, qb_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic signed [26:0] reward_r;
  logic signed [48:0] prod_r;
  logic signed [33:0] t_r;
  logic signed [49:0] pa_r;
  logic signed [50:0] pb_r;
  logic [5:0]         res_state_r;
  logic               res_moved_r, res_written_r;
  logic [31:0]        res_score_r;
  logic signed [26:0] res_reward_r;
  logic               out_tvalid_r;
  logic [71:0]        out_tdata_r;
  logic [31:0]        new_score;

  // row walk
  logic               walk_go;
  logic               walk_act_r;
  logic [5:0]         walk_idx_r;
  logic               rv_r;
  logic [5:0]         rv_idx_r;
  logic               walk_done_r;
  logic signed [31:0] mx_r;
  logic signed [31:0] q_old_r;

  // memories
  logic               core_we;
  logic [CORE_AW-1:0] core_waddr;
  core_ent_t          core_wdata, core_rdata;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  logic [31:0]        tbl_wdata, tbl_rdata;

  rw_req_t rw_req;
  rw_rsp_t rw_rsp;

  nsq_ram #(.W($bits(core_ent_t)), .DEPTH(NUM_CORES)) u_core_mem (
    .clk   (clk),
    .we    (core_we),
    .waddr (core_waddr),
    .wdata (core_wdata),
    .raddr (CORE_AW'(in_core)),
    .rdata (core_rdata)
  );

  nsq_ram #(.W(32), .DEPTH(TBL_DEPTH)) u_tbl_mem (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  nsq_reward u_reward (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rw_req),
    .rsp   (rw_rsp)
  );

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  logic learn_go;
  assign learn_go = (state_r == S_RD) && (kind_r == KIND_OBS) &&
                    (core_rdata.last == s_r) && (core_rdata.cnt >= stable_limit_r);
  assign walk_go  = learn_go;

  assign rw_req.start = (state_r == S_SQ);
  assign rw_req.neg   = neg_r;
  assign rw_req.mag   = mag_r;

  // memory port muxes
  always_comb begin
    core_we    = 1'b0;
    core_waddr = core_r;
    core_wdata = '{last: s_r, start: fit_r, cnt: 8'd0};
    tbl_we     = 1'b0;
    tbl_waddr  = tbl_addr(row_r, s_r);
    tbl_wdata  = new_score;
    tbl_raddr  = (state_r == S_IDLE) ? tbl_addr(in_row, in_col) : tbl_addr(row_r, walk_idx_r);
    case (state_r)
      S_CLR: begin
        core_we    = ({{(13 - CLR_W){1'b0}}, clr_idx_r} < 13'(NUM_CORES));
        core_waddr = CORE_AW'(clr_idx_r);
        core_wdata = '{last: NO_STATE, start: 24'd0, cnt: 8'd0};
        tbl_we     = ({{(13 - CLR_W){1'b0}}, clr_idx_r} < 13'(TBL_DEPTH));
        tbl_waddr  = TBL_AW'(clr_idx_r);
        tbl_wdata  = 32'd0;
      end
      S_IDLE: begin
        tbl_we    = in_fire && (in_tuser == KIND_WR) && ok_tbl;
        tbl_waddr = tbl_addr(in_row, in_col);
        tbl_wdata = in_ev;
      end
      S_RD: begin
        if (kind_r == KIND_OBS && !learn_go) begin
          core_we = 1'b1;
          if (core_rdata.last == s_r) begin
            core_wdata = '{last: s_r, start: core_rdata.start, cnt: core_rdata.cnt + 8'd1};
          end
        end
      end
      S_WR: begin
        core_we = 1'b1;
        tbl_we  = 1'b1;
      end
      default: core_we = 1'b0;
    endcase
  end

  // arithmetic
  logic [23:0]        div_in;
  logic [48:0]        dprod;
  logic [17:0]        q100;
  logic signed [18:0] dd;
  logic signed [35:0] dq;
  logic signed [32:0] rnd_disc;
  logic signed [51:0] acc;
  logic signed [35:0] rr;
  logic [31:0]        mag_nxt;
  logic               neg_nxt;

  assign div_in   = (state_r == S_QA) ? fit_r : sf_r;
  assign dprod    = {25'b0, div_in} * {24'b0, DIV100_M};
  assign q100     = dprod[48:31];
  assign dd       = $signed({1'b0, qa_r}) - $signed({1'b0, qb_r});
  assign dq       = dd * $signed({1'b0, delta_scale_r});
  assign rnd_disc = 33'((prod_r + 49'sd32768) >>> 16);
  assign acc      = 52'(pa_r) + 52'(pb_r);
  assign rr       = 36'((acc + 52'sd32768) >>> 16);

  always_comb begin
    if (rr > 36'sd2147483647) begin
      new_score = 32'h7fff_ffff;
    end else if (rr < -36'sd2147483648) begin
      new_score = 32'h8000_0000;
    end else begin
      new_score = rr[31:0];
    end
  end

  always_comb begin
    if (dq > 36'sd2147483648) begin
      mag_nxt = 32'h8000_0000;
      neg_nxt = 1'b0;
    end else if (dq < -36'sd2147483648) begin
      mag_nxt = 32'h8000_0000;
      neg_nxt = 1'b1;
    end else begin
      neg_nxt = dq[35];
      mag_nxt = dq[35] ? 32'(-dq) : 32'(dq);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (clr_idx_r == CLR_W'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_r        <= in_tuser;
            core_r        <= CORE_AW'(in_core);
            row_r         <= in_row;
            s_r           <= nbr_state(in_a, in_b, in_c);
            fit_r         <= in_fit;
            res_state_r   <= 6'd0;
            res_moved_r   <= 1'b0;
            res_written_r <= 1'b0;
            res_score_r   <= (in_tuser == KIND_WR && ok_tbl) ? in_ev : 32'd0;
            res_reward_r  <= 27'sd0;
            if (in_tuser == KIND_WR && ok_tbl) begin
              state_r     <= S_OUT;
            end else if ((in_tuser == KIND_RD && ok_tbl) ||
                         (in_tuser == KIND_OBS && ok_obs)) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_RD: begin
          if (kind_r == KIND_RD) begin
            res_score_r <= tbl_rdata;
            state_r     <= S_OUT;
          end else begin
            res_state_r <= s_r;
            if (core_rdata.last != s_r) begin
              res_moved_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (learn_go) begin
              sf_r    <= core_rdata.start;
              state_r <= S_QA;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_QA: begin
          qa_r    <= q100;
          state_r <= S_QB;
        end
        S_QB: begin
          qb_r    <= q100;
          state_r <= S_DQ;
        end
        S_DQ: begin
          mag_r   <= mag_nxt;
          neg_r   <= neg_nxt;
          state_r <= S_SQ;
        end
        S_SQ: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (rw_rsp.done && walk_done_r) begin
            reward_r <= rw_rsp.reward;
            state_r  <= S_DISC;
          end
        end
        S_DISC: begin
          prod_r  <= $signed({1'b0, discount_r}) * mx_r;
          state_r <= S_T;
        end
        S_T: begin
          t_r     <= 34'(reward_r) + 34'(rnd_disc);
          state_r <= S_MA;
        end
        S_MA: begin
          pa_r    <= $signed({1'b0, 17'(17'h10000 - {1'b0, learn_rate_r})}) * q_old_r;
          state_r <= S_MB;
        end
        S_MB: begin
          pb_r    <= $signed({1'b0, learn_rate_r}) * t_r;
          state_r <= S_WR;
        end
        S_WR: begin
          res_written_r <= 1'b1;
          res_score_r   <= new_score;
          res_reward_r  <= reward_r;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {5'b0, res_reward_r, res_score_r, res_written_r, res_moved_r,
                             res_state_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // row maximum and current entry, one table read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_act_r  <= 1'b0;
      rv_r        <= 1'b0;
      walk_done_r <= 1'b0;
    end else begin
      rv_r <= walk_act_r;
      if (walk_go) begin
        walk_act_r  <= 1'b1;
        walk_idx_r  <= 6'd0;
        walk_done_r <= 1'b0;
      end else if (walk_act_r) begin
        rv_idx_r <= walk_idx_r;
        if (walk_idx_r == 6'(Q_STATES - 1)) begin
          walk_act_r <= 1'b0;
        end else begin
          walk_idx_r <= walk_idx_r + 6'd1;
        end
      end
      if (rv_r) begin
        if (rv_idx_r == 6'd0 || $signed(tbl_rdata) > mx_r) begin
          mx_r <= $signed(tbl_rdata);
        end
        if (rv_idx_r == s_r) begin
          q_old_r <= $signed(tbl_rdata);
        end
        if (rv_idx_r == 6'(Q_STATES - 1)) begin
          walk_done_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("word accepted during memory clear");
  a_moved_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("state move and table update in one result");
  a_reward_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[7]) |-> (out_tdata[66:40] == 27'd0))
    else $error("reward without table update");
  a_rwait_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RWAIT && rw_rsp.done && walk_done_r) |=> (state_r == S_DISC))
    else $error("reward wait did not release");
  a_walk_before_reward: assert property (@(posedge clk) disable iff (!rst_n)
    rw_req.start |-> (walk_act_r || rv_r))
    else $error("reward started without row walk");
`endif

endmodule
`default_nettype wire

### bench/neighbor_state_q_learning_update_test.sv
// Self-checking testbench for the neighbor-state Q-learning update block.
`timescale 1ns / 1ps
module neighbor_state_q_learning_update_test import nsq_pkg::*;;

  typedef struct {
    logic [1:0]  kind;
    logic [8:0]  core;
    logic        occ;
    logic [1:0]  row;
    logic [2:0]  na, nb, nc;
    logic [23:0] fit;
    logic [5:0]  col;
    logic [31:0] val;
  } obs_word_t;

  typedef struct {
    logic [5:0]  st;
    logic        moved;
    logic        written;
    logic [31:0] score;
    logic [26:0] reward;
  } upd_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  neighbor_state_q_learning_update i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  obs_word_t   pending_words[$];
  upd_result_t expected_results[$];
  obs_word_t   cur_word;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          calm = 0;
  int          mismatches = 0;

  // predictor copies of configuration and state
  longint unsigned alpha, gamma_q, limit, scale;
  logic [5:0]  core_last[NUM_CORES];
  logic [23:0] core_start[NUM_CORES];
  int          core_cnt[NUM_CORES];
  logic signed [31:0] scores[Q_ROWS][Q_STATES];

  // per-core home neighborhood used to keep cores stable
  logic [2:0] home_a[8], home_b[8], home_c[8];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint fit_reward(input logic [23:0] now, input logic [23:0] start);
    longint d, dq;
    longint unsigned mag, s, root, f;
    d = longint'(now / 100) - longint'(start / 100);
    dq = d * longint'(scale);
    if (dq > (64'sd1 <<< 31)) dq = 64'sd1 <<< 31;
    if (dq < -(64'sd1 <<< 31)) dq = -(64'sd1 <<< 31);
    mag = (dq < 0) ? -dq : dq;
    s = (64'd10 << 32) + mag * mag;
    root = int_sqrt(s);
    f = (64'd200 * mag * 64'd65536 + root / 2) / root;
    return (dq < 0) ? 64'sd6553600 + longint'(f) : 64'sd6553600 - longint'(f);
  endfunction

  function automatic longint round16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  task automatic predict_update(input obs_word_t w);
    upd_result_t r;
    int x, y, z, sx, sy;
    logic [5:0] s;
    longint mx, t, acc, rw, nv;
    r = '{default: '0};
    x = w.na; y = w.nb; z = w.nc;
    if (w.kind == KIND_WR || w.kind == KIND_RD) begin
      if (w.row < Q_ROWS && w.col < Q_STATES) begin
        if (w.kind == KIND_WR) scores[w.row][w.col] = w.val;
        r.score = scores[w.row][w.col];
      end
    end else if (w.kind == KIND_OBS && w.occ && w.core < NUM_CORES && w.row < Q_ROWS &&
                 x + y + z <= 4) begin
      sx = x ? (x * x * x - 18 * x * x + 107 * x) / 6 : 0;
      sy = y ? (11 * y - y * y - 2 * x * y) / 2 : 0;
      s = 6'(sx + sy + z);
      r.st = s;
      if (s != core_last[w.core]) begin
        core_last[w.core] = s;
        core_start[w.core] = w.fit;
        core_cnt[w.core] = 0;
        r.moved = 1;
      end else if (core_cnt[w.core] >= limit) begin
        mx = scores[w.row][0];
        for (int i = 1; i < Q_STATES; i++)
          if (scores[w.row][i] > mx) mx = scores[w.row][i];
        rw = fit_reward(w.fit, core_start[w.core]);
        t = rw + round16(longint'(gamma_q) * mx);
        acc = longint'(65536 - alpha) * longint'(scores[w.row][s]) + longint'(alpha) * t;
        nv = round16(acc);
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        scores[w.row][s] = 32'(nv);
        r.score = 32'(nv);
        r.reward = 27'(rw);
        r.written = 1;
        core_cnt[w.core] = 0;
        core_start[w.core] = w.fit;
      end else begin
        core_cnt[w.core]++;
      end
    end
    expected_results.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_update(cur_word);
        in_gap = calm ? 0 : $urandom_range(0, 17);
        if (in_gap == 0 && pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_tdata <= {5'b0, cur_word.val, cur_word.col, cur_word.fit, cur_word.nc,
                       cur_word.nb, cur_word.na, cur_word.row, cur_word.occ, cur_word.core};
          in_tuser <= cur_word.kind;
        end else begin
          in_tvalid <= 0;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 1) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_tdata <= {5'b0, cur_word.val, cur_word.col, cur_word.fit, cur_word.nc,
                       cur_word.nb, cur_word.na, cur_word.row, cur_word.occ, cur_word.core};
          in_tuser <= cur_word.kind;
          in_tvalid <= 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    upd_result_t e, a;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        a.st = out_tdata[5:0];
        a.moved = out_tdata[6];
        a.written = out_tdata[7];
        a.score = out_tdata[39:8];
        a.reward = out_tdata[66:40];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_tdata);
        end else begin
          e = expected_results.pop_front();
          if (a.st !== e.st || a.moved !== e.moved || a.written !== e.written ||
              a.score !== e.score || a.reward !== e.reward) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st=%0d mv=%b wr=%b score=%h reward=%h",
                        " / got st=%0d mv=%b wr=%b score=%h reward=%h"},
                       e.st, e.moved, e.written, e.score, e.reward,
                       a.st, a.moved, a.written, a.score, a.reward);
          end
        end
        out_hold = calm ? 0 : $urandom_range(0, 17);
        out_tready <= (out_hold == 0);
      end else if (!out_tready) begin
        if (out_hold <= 1) out_tready <= 1;
        else out_hold--;
      end
    end else begin
      out_tready <= 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      REG_LEARN: alpha = v[15:0];
      REG_DISC:  gamma_q = v[15:0];
      REG_LIMIT: limit = v[7:0];
      default:   scale = v[15:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic obs_word_t make_word(input logic [1:0] kind, input int core, input bit occ,
                                          input int row, input int a, input int b, input int c,
                                          input int fit, input int col, input logic [31:0] val);
    obs_word_t w;
    w.kind = kind; w.core = core; w.occ = occ; w.row = row;
    w.na = a; w.nb = b; w.nc = c; w.fit = fit; w.col = col; w.val = val;
    return w;
  endfunction

  task automatic push_random(input int n);
    obs_word_t w;
    int sel, k;
    logic [23:0] base;
    for (int i = 0; i < n; i++) begin
      w = make_word(KIND_OBS, 0, 1, 0, 0, 0, 0, 0, 0, $urandom);
      w.fit = $urandom;
      w.col = $urandom_range(0, 34);
      w.row = $urandom_range(0, 2);
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        k = $urandom_range(0, 7);
        w.core = (k == 7) ? 399 : k;
        if ($urandom_range(0, 9) == 0) begin
          home_a[k] = $urandom_range(0, 4);
          home_b[k] = $urandom_range(0, 4 - home_a[k]);
          home_c[k] = $urandom_range(0, 4 - home_a[k] - home_b[k]);
        end
        w.na = home_a[k]; w.nb = home_b[k]; w.nc = home_c[k];
        if ($urandom_range(0, 1)) begin
          base = 24'd1000000;
          w.fit = base + $urandom_range(0, 20000);
        end
      end else if (sel < 80) begin
        w.kind = KIND_WR;
        if ($urandom_range(0, 3) == 0) w.val = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      end else if (sel < 90) begin
        w.kind = KIND_RD;
      end else begin
        w.kind = $urandom_range(0, 3);
        w.core = $urandom_range(0, 511);
        w.occ = $urandom_range(0, 1);
        w.row = $urandom_range(0, 3);
        w.na = $urandom_range(0, 7);
        w.nb = $urandom_range(0, 7);
        w.nc = $urandom_range(0, 7);
        w.col = $urandom_range(0, 63);
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    alpha = 655; gamma_q = 39322; limit = 200; scale = 197;
    for (int i = 0; i < NUM_CORES; i++) begin
      core_last[i] = NO_STATE; core_start[i] = 0; core_cnt[i] = 0;
    end
    for (int r = 0; r < Q_ROWS; r++)
      for (int c = 0; c < Q_STATES; c++) scores[r][c] = 0;
    for (int k = 0; k < 8; k++) begin
      home_a[k] = k % 5; home_b[k] = 0; home_c[k] = (k % 5 == 0) ? 4 : 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    repeat (450) @(posedge clk);

    // directed words
    pending_words.push_back(make_word(KIND_WR, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff));
    pending_words.push_back(make_word(KIND_WR, 0, 0, 2, 0, 0, 0, 0, 34, 32'h80000000));
    pending_words.push_back(make_word(KIND_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_RD, 0, 0, 2, 0, 0, 0, 0, 34, 0));
    pending_words.push_back(make_word(KIND_RD, 0, 0, 3, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_WR, 0, 0, 1, 0, 0, 0, 0, 35, 32'h12345678));
    pending_words.push_back(make_word(KIND_RD, 0, 0, 1, 0, 0, 0, 0, 63, 0));
    pending_words.push_back(make_word(2'd3, 5, 1, 0, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 5, 0, 0, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 400, 1, 0, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 511, 1, 0, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 5, 1, 3, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 5, 1, 0, 4, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 5, 1, 0, 7, 7, 7, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 1, 1, 1, 4, 0, 0, 24'hffffff, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 2, 1, 2, 0, 4, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 3, 1, 0, 0, 0, 4, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 399, 1, 2, 1, 2, 1, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 399, 1, 2, 1, 2, 1, 0, 0, 0));
    pending_words.push_back(make_word(KIND_OBS, 4, 1, 0, 2, 1, 1, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_LEARN, p == 1 ? 0 : p == 2 ? 65535 : $urandom_range(0, 65535));
      write_reg(REG_DISC, p == 1 ? 65535 : p == 2 ? 0 : $urandom_range(0, 65535));
      write_reg(REG_LIMIT, p == 1 ? 1 : p == 3 ? 255 : $urandom_range(1, 4));
      write_reg(REG_SCALE, p == 1 ? 0 : p == 2 ? 65535 : $urandom_range(0, 65535));
      calm = (p % 3 == 2);
      if (p == 3)
        for (int i = 0; i < 260; i++)
          pending_words.push_back(make_word(KIND_OBS, 6, 1, 1, 1, 1, 1, $urandom, 0, 0));
      push_random(p == 3 ? 20 : 150);
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
